### sv/dsa_pkg.sv
// ----------------------------------------------------------------------------
// dsa_pkg
// Types, constants and zone-table helpers shared by the disk sector allocator.
// ----------------------------------------------------------------------------
package dsa_pkg;

   localparam int TRACK_W  = 6;
   localparam int SECTOR_W = 5;
   localparam int MAP_W    = 21;
   localparam int COUNT_W  = 5;
   localparam int ILV_W    = 5;

   localparam logic [TRACK_W-1:0] DIR_TRACK     = 6'd18;
   localparam logic [ILV_W-1:0]   ILV_RESET     = 5'd10;
   localparam logic [COUNT_W-1:0] DIR_RESET_CNT = 5'd17;

   typedef enum logic [1:0] {
      MODE_FIRST = 2'd0,
      MODE_NEXT  = 2'd1,
      MODE_TAKE  = 2'd2,
      MODE_FREE  = 2'd3
   } mode_type;

   typedef struct packed {
      mode_type                mode;
      logic [TRACK_W-1:0]      track;
      logic [SECTOR_W-1:0]     sector;
   } req_type;

   typedef struct packed {
      logic                    ok;
      logic [TRACK_W-1:0]      out_track;
      logic [SECTOR_W-1:0]     out_sector;
      logic [COUNT_W-1:0]      track_free_count;
   } rsp_type;

   typedef struct packed {
      logic [MAP_W-1:0]        free_map;
      logic [COUNT_W-1:0]      free_count;
   } entry_type;

   typedef struct packed {
      logic                    en;
      logic [TRACK_W-1:0]      track;
      entry_type               entry;
   } store_wr_type;

   // zone table: sectors per track
   function automatic logic [SECTOR_W-1:0] sectors_of(input logic [TRACK_W-1:0] track);
      logic [SECTOR_W-1:0] n;
      if (track <= 6'd17) begin
         n = 5'd21;
      end else if (track <= 6'd24) begin
         n = 5'd19;
      end else if (track <= 6'd30) begin
         n = 5'd18;
      end else begin
         n = 5'd17;
      end
      return n;
   endfunction

   // contents of a track right after reset
   function automatic entry_type reset_entry(input logic [TRACK_W-1:0] track);
      entry_type           e;
      logic [SECTOR_W-1:0] n;
      n = sectors_of(track);
      e.free_map   = ~({MAP_W{1'b1}} << n);
      e.free_count = n;
      if (track == DIR_TRACK) begin
         e.free_map   = e.free_map & ~MAP_W'(3);
         e.free_count = DIR_RESET_CNT;
      end
      return e;
   endfunction

endpackage

### sv/dsa_track_store.sv
// ----------------------------------------------------------------------------
// dsa_track_store
// Per-track free map and free count memory, one read and one write port,
// registered read. Entries never written read back as their reset contents.
// ----------------------------------------------------------------------------
module dsa_track_store #(
   parameter int TRACKS = 35
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [dsa_pkg::TRACK_W-1:0]   rd_track,
   output dsa_pkg::entry_type            rd_data,
   input  dsa_pkg::store_wr_type         wr
);

   localparam int AW = $clog2(TRACKS);

   dsa_pkg::entry_type               mem_ff [TRACKS];
   logic [TRACKS-1:0]                valid_ff;
   dsa_pkg::entry_type               rd_entry_ff;
   logic                             rd_vld_ff;
   logic [dsa_pkg::TRACK_W-1:0]      rd_track_ff;
   logic [AW-1:0]                    rd_idx;
   logic [AW-1:0]                    wr_idx;
   logic [dsa_pkg::TRACK_W-1:0]      rd_off;
   logic [dsa_pkg::TRACK_W-1:0]      wr_off;

   assign rd_off = rd_track - dsa_pkg::TRACK_W'(1);
   assign wr_off = wr.track - dsa_pkg::TRACK_W'(1);

   // out-of-range tracks read entry 0; the caller ignores that data
   always_comb begin
      if (rd_track >= dsa_pkg::TRACK_W'(1) && rd_track <= dsa_pkg::TRACK_W'(TRACKS)) begin
         rd_idx = rd_off[AW-1:0];
      end else begin
         rd_idx = '0;
      end
   end

   assign wr_idx = wr_off[AW-1:0];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr_idx] <= wr.entry;
      end
      rd_entry_ff <= mem_ff[rd_idx];
      rd_track_ff <= rd_track;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            valid_ff[wr_idx] <= 1'b1;
         end
         rd_vld_ff <= valid_ff[rd_idx];
      end
   end

   assign rd_data = rd_vld_ff ? rd_entry_ff : dsa_pkg::reset_entry(rd_track_ff);

endmodule

### sv/dsa_sector_pick.sv
// ----------------------------------------------------------------------------
// dsa_sector_pick
// Priority encoder over one track's free map: lowest free sector, optionally
// searching circularly from a start sector.
// ----------------------------------------------------------------------------
module dsa_sector_pick (
   input  logic [dsa_pkg::MAP_W-1:0]     free_map,
   input  logic [dsa_pkg::SECTOR_W-1:0]  start,
   input  logic                          use_start,
   output logic                          found,
   output logic [dsa_pkg::SECTOR_W-1:0]  sector
);

   logic [dsa_pkg::MAP_W-1:0] masked;

   function automatic logic [dsa_pkg::SECTOR_W-1:0] lowest(
      input logic [dsa_pkg::MAP_W-1:0] v
   );
      logic [dsa_pkg::SECTOR_W-1:0] idx;
      idx = '0;
      for (int i = dsa_pkg::MAP_W - 1; i >= 0; i--) begin
         if (v[i]) begin
            idx = dsa_pkg::SECTOR_W'(i);
         end
      end
      return idx;
   endfunction

   assign masked = free_map & ({dsa_pkg::MAP_W{1'b1}} << start);

   always_comb begin
      found = |free_map;
      if (use_start && (|masked)) begin
         sector = lowest(masked);
      end else begin
         sector = lowest(free_map);
      end
   end

endmodule

### sv/disk_sector_allocator_unit.sv
// ----------------------------------------------------------------------------
// disk_sector_allocator_unit
// Free-sector bookkeeping for a zoned disk: allocate first, allocate next,
// allocate a given sector, free a given sector.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid / req_stall / req_payload) takes one request with
//   mode, track and sector; rsp channel (rsp_valid / rsp_stall / rsp_payload)
//   returns exactly one result per request. csr port writes the interleave.
//   Each request passes a lookup step (registered track memory read), a
//   decision step and a reply step: explicit allocate, explicit free,
//   refused requests and hits on the request's own track go from the
//   decision step straight to the reply step, and the next request is
//   taken only after the reply step has loaded the output register.
//   Searches walk the other tracks through the shared sector picker, one
//   candidate track per cycle with the track memory read pipelined one
//   step ahead. The track memory's single read port sets that pace.
//   req_stall is high while a request is in work. A finished result waits in
//   the output register while the next request is already being worked on;
//   if the receiver stalls, the block holds the next result until the output
//   register frees up. Reset gives an empty disk with the directory track's
//   first two sectors in use and interleave 10; no clearing pass is needed.
// ----------------------------------------------------------------------------
module disk_sector_allocator_unit #(
   parameter int TRACKS = 35
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  dsa_pkg::req_type              req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output dsa_pkg::rsp_type              rsp_payload,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [dsa_pkg::ILV_W-1:0]     csr_data
);

   localparam int REACH  = (TRACKS - 18 > 17) ? (TRACKS - 18) : 17;
   localparam int DIST_W = $clog2(REACH + 1);
   localparam logic [dsa_pkg::TRACK_W-1:0] LAST_TRACK = dsa_pkg::TRACK_W'(TRACKS);

   localparam logic [1:0] SEG_AWAY  = 2'd1;
   localparam logic [1:0] SEG_BACK  = 2'd2;
   localparam logic [1:0] SEG_OTHER = 2'd3;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_LOOKUP = 5'b00010,
      ST_DECIDE = 5'b00100,
      ST_SEARCH = 5'b01000,
      ST_REPLY  = 5'b10000
   } state_type;

   typedef struct packed {
      logic [dsa_pkg::TRACK_W-1:0] first;
      logic [dsa_pkg::TRACK_W-1:0] last;
      logic                        down;
   } seg_type;

   state_type                        state_ff, state_in;
   dsa_pkg::req_type                 req_ff, req_in;
   dsa_pkg::rsp_type                 res_ff, res_in;
   dsa_pkg::rsp_type                 rsp_ff;
   logic                             rsp_valid_ff;
   logic                             rsp_load;
   logic [dsa_pkg::ILV_W-1:0]        ilv_ff;

   logic                             gen_active_ff, gen_active_in;
   logic                             side_ff, side_in;
   logic [DIST_W-1:0]                dist_ff, dist_in;
   logic [1:0]                       seg_ff, seg_in;
   logic [dsa_pkg::TRACK_W-1:0]      cur_ff, cur_in;
   logic                             exam_valid_ff, exam_valid_in;
   logic [dsa_pkg::TRACK_W-1:0]      exam_track_ff, exam_track_in;

   logic [dsa_pkg::TRACK_W-1:0]      rd_track;
   dsa_pkg::entry_type               rd_data;
   dsa_pkg::store_wr_type            wr;

   logic                             pick_use_start;
   logic                             pick_found;
   logic [dsa_pkg::SECTOR_W-1:0]     pick_sector;
   logic [dsa_pkg::SECTOR_W-1:0]     start_sector;

   logic                             t_ok;
   logic                             sec_ok;
   logic                             bit_free;
   logic [dsa_pkg::MAP_W-1:0]        shifted;
   logic [dsa_pkg::MAP_W-1:0]        sec_bit;
   logic [dsa_pkg::SECTOR_W-1:0]     n_sec;
   logic [dsa_pkg::COUNT_W-1:0]      cnt_dec;
   logic [dsa_pkg::MAP_W-1:0]        pick_bit;

   logic [dsa_pkg::TRACK_W-1:0]      cand;
   logic                             cand_ok;
   logic                             gen_active_nx;
   logic                             side_nx;
   logic [DIST_W-1:0]                dist_nx;
   logic [1:0]                       seg_nx;
   logic [dsa_pkg::TRACK_W-1:0]      cur_nx;
   seg_type                          seg_cur;
   seg_type                          seg_next;
   seg_type                          seg_first;

   // search segments after the request's own track
   function automatic seg_type seg_bounds(input logic [1:0] seg,
                                          input logic [dsa_pkg::TRACK_W-1:0] t);
      seg_type b;
      logic    low;
      low = t < dsa_pkg::DIR_TRACK;
      case (seg)
         SEG_AWAY: begin
            if (low) begin
               b.first = t - dsa_pkg::TRACK_W'(1);
               b.last  = dsa_pkg::TRACK_W'(1);
               b.down  = 1'b1;
            end else begin
               b.first = t + dsa_pkg::TRACK_W'(1);
               b.last  = LAST_TRACK;
               b.down  = 1'b0;
            end
         end
         SEG_BACK: begin
            if (low) begin
               b.first = dsa_pkg::DIR_TRACK - dsa_pkg::TRACK_W'(1);
               b.last  = t + dsa_pkg::TRACK_W'(1);
               b.down  = 1'b1;
            end else begin
               b.first = dsa_pkg::DIR_TRACK + dsa_pkg::TRACK_W'(1);
               b.last  = t - dsa_pkg::TRACK_W'(1);
               b.down  = 1'b0;
            end
         end
         SEG_OTHER: begin
            if (low) begin
               b.first = dsa_pkg::DIR_TRACK + dsa_pkg::TRACK_W'(1);
               b.last  = LAST_TRACK;
               b.down  = 1'b0;
            end else begin
               b.first = dsa_pkg::DIR_TRACK - dsa_pkg::TRACK_W'(1);
               b.last  = dsa_pkg::TRACK_W'(1);
               b.down  = 1'b1;
            end
         end
         default: begin
            b.first = t;
            b.last  = t;
            b.down  = 1'b0;
         end
      endcase
      return b;
   endfunction

   dsa_track_store #(
      .TRACKS   (TRACKS)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .rd_track (rd_track),
      .rd_data  (rd_data),
      .wr       (wr)
   );

   dsa_sector_pick u_pick (
      .free_map  (rd_data.free_map),
      .start     (start_sector),
      .use_start (pick_use_start),
      .found     (pick_found),
      .sector    (pick_sector)
   );

   // request track checks against the looked-up entry
   always_comb begin
      t_ok     = req_ff.track >= dsa_pkg::TRACK_W'(1) && req_ff.track <= LAST_TRACK;
      n_sec    = dsa_pkg::sectors_of(req_ff.track);
      sec_ok   = req_ff.sector < n_sec;
      shifted  = rd_data.free_map >> req_ff.sector;
      bit_free = shifted[0];
      sec_bit  = dsa_pkg::MAP_W'(1) << req_ff.sector;
      pick_bit = dsa_pkg::MAP_W'(1) << pick_sector;
      cnt_dec  = rd_data.free_count - dsa_pkg::COUNT_W'(1);
   end

   // start sector for next-sector allocation, wrapping with minus one
   always_comb begin
      logic [dsa_pkg::SECTOR_W:0] n6;
      logic [dsa_pkg::SECTOR_W:0] sum6;
      logic [dsa_pkg::SECTOR_W:0] w6;
      n6   = {1'b0, n_sec};
      sum6 = {1'b0, req_ff.sector} + {1'b0, ilv_ff};
      if (sum6 >= n6) begin
         w6 = sum6 - n6;
         if (w6 != '0) begin
            w6 = w6 - (dsa_pkg::SECTOR_W + 1)'(1);
         end
      end else begin
         w6 = sum6;
      end
      if (w6 >= n6) begin
         start_sector = '0;
      end else begin
         start_sector = w6[dsa_pkg::SECTOR_W-1:0];
      end
   end

   // candidate track generator
   always_comb begin
      logic [dsa_pkg::TRACK_W:0] lo7;
      logic [dsa_pkg::TRACK_W:0] hi7;
      lo7           = {1'b0, dsa_pkg::DIR_TRACK} - (dsa_pkg::TRACK_W + 1)'(dist_ff);
      hi7           = {1'b0, dsa_pkg::DIR_TRACK} + (dsa_pkg::TRACK_W + 1)'(dist_ff);
      seg_cur       = seg_bounds(seg_ff, req_ff.track);
      seg_next      = seg_bounds(seg_ff + 2'd1, req_ff.track);
      seg_first     = seg_bounds(SEG_AWAY, req_ff.track);
      gen_active_nx = gen_active_ff;
      side_nx       = side_ff;
      dist_nx       = dist_ff;
      seg_nx        = seg_ff;
      cur_nx        = cur_ff;
      if (req_ff.mode == dsa_pkg::MODE_FIRST) begin
         // outward from the directory track: below first, then above
         if (side_ff) begin
            cand    = hi7[dsa_pkg::TRACK_W-1:0];
            cand_ok = hi7 <= (dsa_pkg::TRACK_W + 1)'(TRACKS);
            side_nx = 1'b0;
            dist_nx = dist_ff + DIST_W'(1);
            if (dist_ff == DIST_W'(REACH)) begin
               gen_active_nx = 1'b0;
            end
         end else begin
            cand    = lo7[dsa_pkg::TRACK_W-1:0];
            cand_ok = (dsa_pkg::TRACK_W + 1)'(dist_ff) < {1'b0, dsa_pkg::DIR_TRACK};
            side_nx = 1'b1;
         end
      end else begin
         cand = cur_ff;
         if (seg_cur.down) begin
            cand_ok = cur_ff >= seg_cur.last;
         end else begin
            cand_ok = cur_ff <= seg_cur.last;
         end
         if (!cand_ok || cur_ff == seg_cur.last) begin
            if (seg_ff == SEG_OTHER) begin
               gen_active_nx = 1'b0;
            end else begin
               seg_nx = seg_ff + 2'd1;
               cur_nx = seg_next.first;
            end
         end else if (seg_cur.down) begin
            cur_nx = cur_ff - dsa_pkg::TRACK_W'(1);
         end else begin
            cur_nx = cur_ff + dsa_pkg::TRACK_W'(1);
         end
      end
   end

   // sequencer
   always_comb begin
      state_in       = state_ff;
      req_in         = req_ff;
      res_in         = res_ff;
      gen_active_in  = gen_active_ff;
      side_in        = side_ff;
      dist_in        = dist_ff;
      seg_in         = seg_ff;
      cur_in         = cur_ff;
      exam_valid_in  = 1'b0;
      exam_track_in  = exam_track_ff;
      rd_track       = req_ff.track;
      pick_use_start = 1'b0;
      rsp_load       = 1'b0;
      wr             = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_payload;
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            res_in.ok               = 1'b0;
            res_in.out_track        = req_ff.track;
            res_in.out_sector       = req_ff.sector;
            res_in.track_free_count = t_ok ? rd_data.free_count : '0;
            state_in                = ST_REPLY;
            wr.track                = req_ff.track;
            case (req_ff.mode)
               dsa_pkg::MODE_TAKE: begin
                  if (t_ok && sec_ok && bit_free) begin
                     wr.en                   = 1'b1;
                     wr.entry.free_map       = rd_data.free_map & ~sec_bit;
                     wr.entry.free_count     = cnt_dec;
                     res_in.ok               = 1'b1;
                     res_in.track_free_count = cnt_dec;
                  end
               end
               dsa_pkg::MODE_FREE: begin
                  if (t_ok && sec_ok && !bit_free) begin
                     wr.en                   = 1'b1;
                     wr.entry.free_map       = rd_data.free_map | sec_bit;
                     wr.entry.free_count     = rd_data.free_count + dsa_pkg::COUNT_W'(1);
                     res_in.ok               = 1'b1;
                     res_in.track_free_count = wr.entry.free_count;
                  end
               end
               dsa_pkg::MODE_NEXT: begin
                  if (t_ok && req_ff.track != dsa_pkg::DIR_TRACK) begin
                     pick_use_start = 1'b1;
                     if (pick_found) begin
                        wr.en                   = 1'b1;
                        wr.entry.free_map       = rd_data.free_map & ~pick_bit;
                        wr.entry.free_count     = cnt_dec;
                        res_in.ok               = 1'b1;
                        res_in.out_sector       = pick_sector;
                        res_in.track_free_count = cnt_dec;
                     end else begin
                        // own track full: walk the other tracks
                        gen_active_in = 1'b1;
                        seg_in        = SEG_AWAY;
                        cur_in        = seg_first.first;
                        state_in      = ST_SEARCH;
                     end
                  end
               end
               default: begin
                  gen_active_in = 1'b1;
                  side_in       = 1'b0;
                  dist_in       = DIST_W'(1);
                  state_in      = ST_SEARCH;
               end
            endcase
         end
         ST_SEARCH: begin
            // issue: read the next candidate while the previous one is examined
            if (gen_active_ff) begin
               rd_track      = cand;
               exam_valid_in = cand_ok;
               exam_track_in = cand;
               gen_active_in = gen_active_nx;
               side_in       = side_nx;
               dist_in       = dist_nx;
               seg_in        = seg_nx;
               cur_in        = cur_nx;
            end
            if (exam_valid_ff && pick_found) begin
               wr.en                   = 1'b1;
               wr.track                = exam_track_ff;
               wr.entry.free_map       = rd_data.free_map & ~pick_bit;
               wr.entry.free_count     = cnt_dec;
               res_in.ok               = 1'b1;
               res_in.out_track        = exam_track_ff;
               res_in.out_sector       = pick_sector;
               res_in.track_free_count = cnt_dec;
               gen_active_in           = 1'b0;
               exam_valid_in           = 1'b0;
               state_in                = ST_REPLY;
            end else if (!gen_active_ff && !exam_valid_ff) begin
               // disk full: failure result was prepared on entry
               state_in = ST_REPLY;
            end
         end
         ST_REPLY: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         ilv_ff        <= dsa_pkg::ILV_RESET;
         gen_active_ff <= 1'b0;
         exam_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         gen_active_ff <= gen_active_in;
         exam_valid_ff <= exam_valid_in;
         if (csr_valid && csr_ready) begin
            ilv_ff <= csr_data;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      res_ff        <= res_in;
      side_ff       <= side_in;
      dist_ff       <= dist_in;
      seg_ff        <= seg_in;
      cur_ff        <= cur_in;
      exam_track_ff <= exam_track_in;
      if (rsp_load) begin
         rsp_ff <= res_ff;
      end
   end

   assign req_stall   = state_ff != ST_IDLE;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign csr_ready   = 1'b1;

`ifndef NO_ASSERTIONS
   a_rsp_from_reply: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_REPLY))
      else $error("result appeared without a reply step");

   a_write_track_valid: assert property (@(posedge clock) disable iff (reset)
      wr.en |-> (wr.track >= dsa_pkg::TRACK_W'(1) && wr.track <= LAST_TRACK))
      else $error("store write to a track outside the disk");

   a_exam_in_search: assert property (@(posedge clock) disable iff (reset)
      exam_valid_ff |-> state_ff == ST_SEARCH)
      else $error("search pipeline busy outside a search");

   a_ok_count_bound: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.ok) |->
         rsp_ff.track_free_count <= dsa_pkg::sectors_of(rsp_ff.out_track))
      else $error("free count exceeds sectors of track");

   a_accept_to_lookup: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> state_ff == ST_LOOKUP)
      else $error("accepted transaction did not start a lookup");
`endif

endmodule
